// ----- rtl/ors_pkg.sv -----
// ----------------------------------------------------------------------------
// ors_pkg
// Shared types and constants for the 1-Wire search-ROM sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ors_pkg;

    // Code geometry and counter limit
    localparam int CODE_BITS = 64;
    localparam int COUNT_MAX = 4095;
    localparam int POS_W     = $clog2(CODE_BITS);
    localparam int MARK_W    = POS_W + 1;
    localparam int CNT_W     = $clog2(COUNT_MAX + 1);

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;
    localparam int ROM_W    = 64;
    localparam int FOUND_W  = 12;
    localparam int MAXDEV_W = 12;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_CMD    = 1'b0;
    localparam logic REG_MAXDEV = 1'b1;
    localparam logic [BYTE_W-1:0]   CMD_RESET    = 8'd240;
    localparam logic [MAXDEV_W-1:0] MAXDEV_RESET = '0;

    // Marker for "no branch point"
    localparam logic [MARK_W-1:0] NO_MARK = '1;

    // Input function codes
    localparam logic [FUNC_W-1:0] FN_START = 2'd0;
    localparam logic [FUNC_W-1:0] FN_PRES  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_BITS  = 2'd2;

    // Result actions
    localparam logic [ACTION_W-1:0] ACT_RESET = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_BYTE  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_BIT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CODE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DONE  = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PRES = 2'd1,
        PH_BITS = 2'd2
    } t_phase;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              presence;
        logic              true_bit;
        logic              complement_bit;
    } t_in_item;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   send_byte;
        logic                write_bit;
        logic [ROM_W-1:0]    rom_code;
        logic [FOUND_W-1:0]  found_count;
        logic                search_error;
        logic                last;
    } t_result;

    // Up to three results caused by one item, entry 0 first
    typedef struct packed {
        t_result [2:0] res;
    } t_bundle;

    typedef struct packed {
        logic [BYTE_W-1:0]   search_command;
        logic [MAXDEV_W-1:0] max_devices;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/ors_in_if.sv -----
// ----------------------------------------------------------------------------
// ors_in_if
// Valid/ready channel carrying bus events into the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ors_in_if;
    logic             valid;
    logic             ready;
    ors_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ors_out_if.sv -----
// ----------------------------------------------------------------------------
// ors_out_if
// Valid/ready channel carrying bus requests and search results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ors_out_if;
    logic            valid;
    logic            ready;
    ors_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ors_cfg.sv -----
// ----------------------------------------------------------------------------
// ors_cfg
// APB-style register file: search command byte and device limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ors_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic [ors_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [ors_pkg::DATA_W-1:0] i_pwdata,
    output logic      [ors_pkg::DATA_W-1:0] o_prdata,
    output logic                            o_pready,
    output ors_pkg::t_cfg                   o_cfg
);

    logic [ors_pkg::BYTE_W-1:0]   r_cmd;
    logic [ors_pkg::MAXDEV_W-1:0] r_maxdev;
    logic                         wr_en;
    logic                         reg_sel;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign reg_sel  = i_paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd    <= ors_pkg::CMD_RESET;
            r_maxdev <= ors_pkg::MAXDEV_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                ors_pkg::REG_CMD:    r_cmd    <= i_pwdata[ors_pkg::BYTE_W-1:0];
                ors_pkg::REG_MAXDEV: r_maxdev <= i_pwdata[ors_pkg::MAXDEV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        case (reg_sel)
            ors_pkg::REG_CMD:    o_prdata = ors_pkg::DATA_W'(r_cmd);
            ors_pkg::REG_MAXDEV: o_prdata = ors_pkg::DATA_W'(r_maxdev);
            default: ;
        endcase
    end

    assign o_cfg.search_command = r_cmd;
    assign o_cfg.max_devices    = r_maxdev;

endmodule

`default_nettype wire

// ----- rtl/ors_step.sv -----
// ----------------------------------------------------------------------------
// ors_step
// Search state and the per-event decision: direction bit, branch tracking,
// code assembly and pass control. Emits the results of one event at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ors_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire ors_pkg::t_in_item i_item,
    input  wire ors_pkg::t_cfg     i_cfg,
    input  wire logic              i_slot_free,
    output logic                   o_take,
    output logic                   o_wr,
    output ors_pkg::t_bundle       o_bundle
);

    logic [ors_pkg::CODE_BITS-1:0] r_code, n_code;
    logic [ors_pkg::MARK_W-1:0]    r_bmark, n_bmark;
    logic [ors_pkg::MARK_W-1:0]    r_nbmark, n_nbmark;
    logic [ors_pkg::POS_W-1:0]     r_pos, n_pos;
    logic                          r_pcomp, n_pcomp;
    logic [ors_pkg::CNT_W-1:0]     r_count, n_count;
    ors_pkg::t_phase               r_phase, n_phase;

    logic                          has_res;
    logic                          dir;
    logic [ors_pkg::MARK_W-1:0]    pos_ext;
    logic                          mark_none;
    logic [ors_pkg::CNT_W-1:0]     cnt_inc;
    ors_pkg::t_result              res0, res1, res2;

    assign pos_ext   = {1'b0, r_pos};
    assign mark_none = (r_bmark == ors_pkg::NO_MARK);
    assign cnt_inc   = (32'(r_count) < 32'(ors_pkg::COUNT_MAX)) ?
                       ors_pkg::CNT_W'(r_count + 1'b1) : r_count;

    always_comb begin
        n_code   = r_code;
        n_bmark  = r_bmark;
        n_nbmark = r_nbmark;
        n_pos    = r_pos;
        n_pcomp  = r_pcomp;
        n_count  = r_count;
        n_phase  = r_phase;
        has_res  = 1'b0;
        dir      = 1'b0;
        res0     = '0;
        res1     = '0;
        res2     = '0;

        case (i_item.func)
            ors_pkg::FN_START: begin
                n_code      = '0;
                n_nbmark    = ors_pkg::NO_MARK;
                n_bmark     = ors_pkg::NO_MARK;
                n_count     = '0;
                n_pos       = '0;
                n_pcomp     = 1'b1;
                n_phase     = ors_pkg::PH_PRES;
                has_res     = 1'b1;
                res0.action = ors_pkg::ACT_RESET;
                res0.last   = 1'b1;
            end
            ors_pkg::FN_PRES: begin
                if (r_phase == ors_pkg::PH_PRES) begin
                    has_res   = 1'b1;
                    res0.last = 1'b1;
                    if (!i_item.presence) begin
                        n_count     = '0;
                        n_phase     = ors_pkg::PH_IDLE;
                        res0.action = ors_pkg::ACT_DONE;
                    end else begin
                        n_pos          = '0;
                        n_phase        = ors_pkg::PH_BITS;
                        res0.action    = ors_pkg::ACT_BYTE;
                        res0.send_byte = i_cfg.search_command;
                    end
                end
            end
            ors_pkg::FN_BITS: begin
                if (r_phase == ors_pkg::PH_BITS) begin
                    has_res = 1'b1;
                    if (i_item.true_bit && i_item.complement_bit) begin
                        n_phase           = ors_pkg::PH_IDLE;
                        res0.action       = ors_pkg::ACT_DONE;
                        res0.found_count  = ors_pkg::FOUND_W'(r_count);
                        res0.search_error = 1'b1;
                        res0.last         = 1'b1;
                    end else begin
                        // Both bits zero: devices disagree here, pick a branch
                        if (!i_item.true_bit && !i_item.complement_bit) begin
                            if (!mark_none && pos_ext == r_bmark) begin
                                dir = 1'b1;
                            end else if (mark_none || pos_ext > r_bmark ||
                                         !r_code[r_pos]) begin
                                dir      = 1'b0;
                                n_pcomp  = 1'b0;
                                n_nbmark = pos_ext;
                            end else begin
                                dir = 1'b1;
                            end
                        end else begin
                            dir = i_item.true_bit;
                        end
                        n_code[r_pos]  = dir;
                        res0.action    = ors_pkg::ACT_BIT;
                        res0.write_bit = dir;

                        if (r_pos == ors_pkg::POS_W'(ors_pkg::CODE_BITS - 1)) begin
                            res1.action   = ors_pkg::ACT_CODE;
                            res1.rom_code = ors_pkg::ROM_W'(n_code);
                            n_count       = cnt_inc;
                            n_pos         = '0;
                            res2.last     = 1'b1;
                            if (!n_pcomp && (i_cfg.max_devices == '0 ||
                                32'(cnt_inc) < 32'(i_cfg.max_devices))) begin
                                n_pcomp     = 1'b1;
                                n_bmark     = n_nbmark;
                                n_phase     = ors_pkg::PH_PRES;
                                res2.action = ors_pkg::ACT_RESET;
                            end else begin
                                n_phase          = ors_pkg::PH_IDLE;
                                res2.action      = ors_pkg::ACT_DONE;
                                res2.found_count = ors_pkg::FOUND_W'(cnt_inc);
                            end
                        end else begin
                            n_pos     = ors_pkg::POS_W'(r_pos + 1'b1);
                            res0.last = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Events that cause nothing pass straight through
    assign o_take = i_vld && (!has_res || i_slot_free);
    assign o_wr   = o_take && has_res;
    assign o_bundle.res[0] = res0;
    assign o_bundle.res[1] = res1;
    assign o_bundle.res[2] = res2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code   <= '0;
            r_bmark  <= ors_pkg::NO_MARK;
            r_nbmark <= ors_pkg::NO_MARK;
            r_pos    <= '0;
            r_pcomp  <= 1'b1;
            r_count  <= '0;
            r_phase  <= ors_pkg::PH_IDLE;
        end else if (o_take) begin
            r_code   <= n_code;
            r_bmark  <= n_bmark;
            r_nbmark <= n_nbmark;
            r_pos    <= n_pos;
            r_pcomp  <= n_pcomp;
            r_count  <= n_count;
            r_phase  <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ors_obuf.sv -----
// ----------------------------------------------------------------------------
// ors_obuf
// Result register: holds the results of one event and hands them out one
// beat at a time, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ors_obuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire ors_pkg::t_bundle i_bundle,
    output logic                  o_slot_free,
    ors_out_if.source             o_out
);

    ors_pkg::t_bundle r_bun;
    logic             r_vld;
    logic [1:0]       r_idx;
    ors_pkg::t_result cur;
    logic             beat;

    assign cur         = r_bun.res[r_idx];
    assign beat        = r_vld && o_out.ready;
    assign o_slot_free = !r_vld || (beat && cur.last);
    assign o_out.valid = r_vld;
    assign o_out.data  = cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (i_wr) begin
            r_vld <= 1'b1;
            r_idx <= '0;
        end else if (beat) begin
            // Advance within the event, drop after its final beat
            if (cur.last) begin
                r_vld <= 1'b0;
            end
            r_idx <= 2'(r_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_bun <= i_bundle;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/onewire_rom_search_core.sv -----
// ----------------------------------------------------------------------------
// onewire_rom_search_core
// 1-Wire search-ROM sequencer: turns bus events into bus requests and
// reports each device code found.
// ----------------------------------------------------------------------------
//  port     dir  kind          payload
//  i_in     in   valid/ready   func, presence, true_bit, complement_bit
//  o_out    out  valid/ready   action, send_byte, write_bit, rom_code,
//                              found_count, search_error, last
//  p*       in   APB write/rd  search_command (0x0), max_devices (0x4)
//
//  An event is registered on entry and decided once the result register is
//  free; the decision writes all of its results (one to three) into the result
//  register, which offers the first beat. An event with one result frees the
//  result register on its beat, so one event per cycle while the output is
//  ready; one that completes a code takes three output beats, held in the
//  single result register. Events with no result are absorbed without waiting.
//  Reset is synchronous: no branch point, no codes, idle phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module onewire_rom_search_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    ors_in_if.sink                          i_in,
    ors_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ors_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ors_pkg::DATA_W-1:0] pwdata,
    output logic      [ors_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    ors_pkg::t_cfg     cfg;
    ors_pkg::t_in_item r_in;
    logic              r_in_vld;
    logic              take;
    logic              wr;
    logic              slot_free;
    ors_pkg::t_bundle  bundle;

    ors_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    // Input register: refill as soon as the held event is taken
    assign i_in.ready = !r_in_vld || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    ors_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (r_in_vld),
        .i_item      (r_in),
        .i_cfg       (cfg),
        .i_slot_free (slot_free),
        .o_take      (take),
        .o_wr        (wr),
        .o_bundle    (bundle)
    );

    ors_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_bundle    (bundle),
        .o_slot_free (slot_free),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
